// File: design/ducking_mixer_gain_ramp_unit_defines.svh
// Assertion helpers for the ducking mixer.
`ifndef DUCKING_MIXER_GAIN_RAMP_UNIT_DEFINES_SVH
`define DUCKING_MIXER_GAIN_RAMP_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DMG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: design/dmg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmg_pkg;

    // Q16 unity gain and percent clamp
    localparam int unsigned GAIN_ONE    = 65536;
    localparam int unsigned PERCENT_MAX = 100;

    // Shared restoring divider
    localparam int unsigned DIV_W     = 24;
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic {
        CMD_MIX = 1'b0,
        CMD_SET = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               command;
        logic signed [15:0] foreground_left;
        logic signed [15:0] foreground_right;
        logic signed [15:0] background_left;
        logic signed [15:0] background_right;
        logic        [7:0]  target_percent;
        logic        [23:0] ramp_length;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] mixed_left;
        logic signed [15:0] mixed_right;
    } out_word_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_STEP = 7'b0000100,
        ST_MULL = 7'b0001000,
        ST_MULR = 7'b0010000,
        ST_SUM  = 7'b0100000,
        ST_PUSH = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// File: design/ducking_mixer_gain_ramp_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ducking stereo mixer: each mix word gives foreground plus Q16-scaled background
// per channel, saturated to 16 bits; each set word loads a new background target
// (percent, clamped to 100) and a linear ramp length in frames. One word is worked
// at a time and item_ready is high only while the sequencer is idle. Set words,
// and mix words during a ramp longer than one frame, pass through the 24-step
// restoring divider (one quotient bit per cycle, shared by the percent conversion
// and the ramp step); other mix words skip it. The single 16x18 multiplier serves
// both channels in turn. The result sits in an output register, so a new word is
// taken while the last result waits.
module ducking_mixer_gain_ramp_unit
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire dmg_pkg::in_word_t  item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output dmg_pkg::out_word_t      result
);

`include "ducking_mixer_gain_ramp_unit_defines.svh"

    localparam logic [16:0] GAIN_UNITY = 17'(dmg_pkg::GAIN_ONE);
    localparam logic [6:0]  PCT_MAX    = 7'(dmg_pkg::PERCENT_MAX);
    localparam logic [dmg_pkg::DIV_CNT_W-1:0] DIV_LAST =
        dmg_pkg::DIV_CNT_W'(dmg_pkg::DIV_W - 1);

    // Registers
    dmg_pkg::state_t state_reg, state_next;
    logic [16:0] current_gain_reg, current_gain_next;
    logic [16:0] target_gain_reg, target_gain_next;
    logic [23:0] ramp_left_reg, ramp_left_next;
    logic        op_set_reg, op_set_next;
    logic [23:0] ramp_len_reg, ramp_len_next;
    logic        delta_neg_reg, delta_neg_next;
    logic        delta_nz_reg, delta_nz_next;
    logic signed [15:0] fg_l_reg, fg_l_next, fg_r_reg, fg_r_next;
    logic signed [15:0] bg_l_reg, bg_l_next, bg_r_reg, bg_r_next;
    logic [dmg_pkg::DIV_W-1:0] div_rem_reg, div_rem_next;
    logic [dmg_pkg::DIV_W-1:0] div_quo_reg, div_quo_next;
    logic [dmg_pkg::DIV_W-1:0] div_den_reg, div_den_next;
    logic [dmg_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic signed [32:0] prod_reg, prod_next;
    logic signed [15:0] res_l_reg, res_l_next;
    logic signed [15:0] res_r_reg, res_r_next;
    logic               out_valid_reg, out_valid_next;
    dmg_pkg::out_word_t out_word_reg, out_word_next;

    // Divider step: one quotient bit per cycle
    logic [dmg_pkg::DIV_W:0]   div_shift;
    logic [dmg_pkg::DIV_W+1:0] div_trial;
    logic                      div_neg;

    assign div_shift = {div_rem_reg, div_quo_reg[dmg_pkg::DIV_W-1]};
    assign div_trial = {1'b0, div_shift} - {2'b00, div_den_reg};
    assign div_neg   = div_trial[dmg_pkg::DIV_W+1];

    // Shared multiplier: background sample times current gain
    logic signed [32:0] mul_bg, mul_gain, mul_prod;
    logic signed [15:0] mul_src;

    assign mul_src  = state_reg == dmg_pkg::ST_MULL ? bg_l_reg : bg_r_reg;
    assign mul_bg   = {{17{mul_src[15]}}, mul_src};
    assign mul_gain = {16'b0, current_gain_reg};
    assign mul_prod = mul_bg * mul_gain;

    // Divide product by 65536 toward zero, add foreground, saturate
    function automatic logic signed [15:0] mix_sat(input logic signed [32:0] p,
                                                   input logic signed [15:0] fg);
        logic signed [32:0] biased;
        logic signed [17:0] sum;
        begin
            biased = p + (p[32] ? 33'sd65535 : 33'sd0);
            sum    = {{2{fg[15]}}, fg} + {biased[32], biased[32:16]};
            if (sum > 18'sd32767)
                mix_sat = 16'sh7fff;
            else if (sum < -18'sd32768)
                mix_sat = 16'sh8000;
            else
                mix_sat = sum[15:0];
        end
    endfunction

    // Ramp step magnitude and gain difference
    logic signed [17:0] delta;
    logic [16:0]        delta_abs;
    logic [16:0]        step_mag;
    logic [6:0]         pct;

    assign delta     = $signed({1'b0, target_gain_reg}) - $signed({1'b0, current_gain_reg});
    assign delta_abs = delta[17] ? 17'(-delta) : delta[16:0];
    assign step_mag  = (div_quo_reg[16:0] == 17'd0 && delta_nz_reg) ? 17'd1
                                                                    : div_quo_reg[16:0];
    assign pct       = item.target_percent > 8'(PCT_MAX) ? PCT_MAX
                                                         : item.target_percent[6:0];

    assign item_ready   = state_reg == dmg_pkg::ST_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        current_gain_next = current_gain_reg;
        target_gain_next  = target_gain_reg;
        ramp_left_next    = ramp_left_reg;
        op_set_next       = op_set_reg;
        ramp_len_next     = ramp_len_reg;
        delta_neg_next    = delta_neg_reg;
        delta_nz_next     = delta_nz_reg;
        fg_l_next         = fg_l_reg;
        fg_r_next         = fg_r_reg;
        bg_l_next         = bg_l_reg;
        bg_r_next         = bg_r_reg;
        div_rem_next      = div_rem_reg;
        div_quo_next      = div_quo_reg;
        div_den_next      = div_den_reg;
        div_cnt_next      = div_cnt_reg;
        prod_next         = prod_reg;
        res_l_next        = res_l_reg;
        res_r_next        = res_r_reg;
        out_word_next     = out_word_reg;
        out_valid_next    = out_valid_reg && !result_ready;

        unique case (state_reg)
            dmg_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    fg_l_next    = item.foreground_left;
                    fg_r_next    = item.foreground_right;
                    bg_l_next    = item.background_left;
                    bg_r_next    = item.background_right;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    if (item.command == dmg_pkg::CMD_SET)
                    begin
                        // target = pct * 65536 / 100
                        op_set_next   = 1'b1;
                        ramp_len_next = item.ramp_length;
                        div_quo_next  = {1'b0, pct, 16'b0};
                        div_den_next  = dmg_pkg::DIV_W'(PCT_MAX);
                        state_next    = dmg_pkg::ST_DIV;
                    end
                    else
                    begin
                        op_set_next    = 1'b0;
                        delta_neg_next = delta[17];
                        delta_nz_next  = delta != 18'sd0;
                        div_quo_next   = dmg_pkg::DIV_W'(delta_abs);
                        div_den_next   = ramp_left_reg;
                        if (ramp_left_reg == 24'd0)
                            state_next = dmg_pkg::ST_MULL;
                        else if (ramp_left_reg == 24'd1)
                        begin
                            // last ramp frame snaps to target
                            current_gain_next = target_gain_reg;
                            ramp_left_next    = 24'd0;
                            state_next        = dmg_pkg::ST_MULL;
                        end
                        else
                            state_next = dmg_pkg::ST_DIV;
                    end
                end
            end

            dmg_pkg::ST_DIV:
            begin
                div_quo_next = {div_quo_reg[dmg_pkg::DIV_W-2:0], !div_neg};
                div_rem_next = div_neg ? div_shift[dmg_pkg::DIV_W-1:0]
                                       : div_trial[dmg_pkg::DIV_W-1:0];
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = dmg_pkg::ST_STEP;
            end

            dmg_pkg::ST_STEP:
            begin
                if (op_set_reg)
                begin
                    target_gain_next = div_quo_reg[16:0];
                    ramp_left_next   = ramp_len_reg;
                    if (ramp_len_reg == 24'd0)
                        current_gain_next = div_quo_reg[16:0];
                    state_next = dmg_pkg::ST_IDLE;
                end
                else
                begin
                    // at least two frames left here, so no snap
                    current_gain_next = delta_neg_reg ? current_gain_reg - step_mag
                                                      : current_gain_reg + step_mag;
                    ramp_left_next    = ramp_left_reg - 24'd1;
                    state_next        = dmg_pkg::ST_MULL;
                end
            end

            dmg_pkg::ST_MULL:
            begin
                prod_next  = mul_prod;
                state_next = dmg_pkg::ST_MULR;
            end

            dmg_pkg::ST_MULR:
            begin
                res_l_next = mix_sat(prod_reg, fg_l_reg);
                prod_next  = mul_prod;
                state_next = dmg_pkg::ST_SUM;
            end

            dmg_pkg::ST_SUM:
            begin
                res_r_next = mix_sat(prod_reg, fg_r_reg);
                state_next = dmg_pkg::ST_PUSH;
            end

            dmg_pkg::ST_PUSH:
            begin
                // load output once the previous word has left
                if (!out_valid_reg || result_ready)
                begin
                    out_word_next.mixed_left  = res_l_reg;
                    out_word_next.mixed_right = res_r_reg;
                    out_valid_next            = 1'b1;
                    state_next                = dmg_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dmg_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dmg_pkg::ST_IDLE;
            current_gain_reg <= GAIN_UNITY;
            target_gain_reg  <= GAIN_UNITY;
            ramp_left_reg    <= '0;
            out_valid_reg    <= 1'b0;
            div_cnt_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            current_gain_reg <= current_gain_next;
            target_gain_reg  <= target_gain_next;
            ramp_left_reg    <= ramp_left_next;
            out_valid_reg    <= out_valid_next;
            div_cnt_reg      <= div_cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        op_set_reg    <= op_set_next;
        ramp_len_reg  <= ramp_len_next;
        delta_neg_reg <= delta_neg_next;
        delta_nz_reg  <= delta_nz_next;
        fg_l_reg      <= fg_l_next;
        fg_r_reg      <= fg_r_next;
        bg_l_reg      <= bg_l_next;
        bg_r_reg      <= bg_r_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_den_reg   <= div_den_next;
        prod_reg      <= prod_next;
        res_l_reg     <= res_l_next;
        res_r_reg     <= res_r_next;
        out_word_reg  <= out_word_next;
    end

    // Checks
    `DMG_ASSERT_NOW(a_idle_ramp_at_target, clk, rst_n,
        ramp_left_reg == 24'd0, current_gain_reg == target_gain_reg)
    `DMG_ASSERT_NOW(a_gain_in_range, clk, rst_n,
        1'b1, current_gain_reg <= GAIN_UNITY && target_gain_reg <= GAIN_UNITY)
    `DMG_ASSERT_NOW(a_div_count_bound, clk, rst_n,
        state_reg == dmg_pkg::ST_DIV, div_cnt_reg <= DIV_LAST)
    `DMG_ASSERT_NEXT(a_mix_starts_work, clk, rst_n,
        item_valid && item_ready && item.command == dmg_pkg::CMD_MIX,
        state_reg == dmg_pkg::ST_DIV || state_reg == dmg_pkg::ST_MULL)

endmodule

`default_nettype wire
